>>> rtl/core/srte_pkg.sv
// ----------------------------------------------------------------------------
// srte_pkg
// shared types, register indexes, codes and character helpers for the
// s-record text encoder
// ----------------------------------------------------------------------------
package srte_pkg;

    localparam int DEF_MAX_RECORD_BYTES = 32;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int CNT_W       = 6;

    localparam logic [1:0] REG_RECORD_TYPE   = 2'd0;
    localparam logic [1:0] REG_RECORD_LENGTH = 2'd1;
    localparam logic [1:0] REG_BASE_ADDRESS  = 2'd2;

    localparam logic [1:0]  RST_RECORD_TYPE   = 2'd3;
    localparam logic [5:0]  RST_RECORD_LENGTH = 6'd32;
    localparam logic [31:0] RST_BASE_ADDRESS  = 32'd0;

    localparam logic [1:0] MODE_START  = 2'd0;
    localparam logic [1:0] MODE_DATA   = 2'd1;
    localparam logic [1:0] MODE_FINISH = 2'd2;

    localparam logic [6:0] CHAR_S  = 7'h53;
    localparam logic [6:0] CHAR_NL = 7'h0A;

    localparam logic [3:0] TYPE_HEADER = 4'd0;
    localparam logic [3:0] TYPE_COUNT  = 4'd5;

    typedef struct packed {
        logic [1:0]  mode;
        logic [7:0]  data_byte;
        logic        block_end;
        logic        use_address;
        logic [31:0] new_address;
    } in_item_t;

    typedef struct packed {
        logic [6:0] char_first;
        logic [6:0] char_second;
        logic [1:0] char_count;
        logic       record_end;
        logic       last;
    } out_item_t;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_HEAD  = 7'b0000010,
        ST_COUNT = 7'b0000100,
        ST_ADDR  = 7'b0001000,
        ST_DATA  = 7'b0010000,
        ST_CSUM  = 7'b0100000,
        ST_NL    = 7'b1000000
    } state_t;

    typedef enum logic [1:0] {
        REC_HDR  = 2'd0,
        REC_DATA = 2'd1,
        REC_CNT  = 2'd2
    } kind_t;

    typedef struct packed {
        logic             accept;
        logic             emit;
        state_t           state;
        kind_t            kind;
        logic [CNT_W-1:0] idx;
        logic             last;
        logic             rec_done;
    } cmd_t;

    typedef struct packed {
        logic             out_free;
        logic             data_flush;
        logic             pending;
        logic [2:0]       addr_bytes;
        logic [CNT_W-1:0] data_len;
    } sts_t;

    function automatic logic [6:0] hex_char(input logic [3:0] nib);
        logic [6:0] c;
        if (nib < 4'd10)
        begin
            c = 7'h30 + {3'b000, nib};
        end
        else
        begin
            c = 7'h37 + {3'b000, nib};
        end
        return c;
    endfunction

    function automatic logic [7:0] hdr_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0:    b = 8'h48;
            2'd1:    b = 8'h44;
            2'd2:    b = 8'h52;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/srte_ram.sv
// ----------------------------------------------------------------------------
// srte_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module srte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/srte_datapath.sv
// ----------------------------------------------------------------------------
// srte_datapath
// configuration, record state, byte buffer, checksum and the output beat
// register of the s-record text encoder
// ----------------------------------------------------------------------------
module srte_datapath #(
    parameter int MAX_RECORD_BYTES = srte_pkg::DEF_MAX_RECORD_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srte_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  srte_pkg::in_item_t               in_data,
    input  srte_pkg::cmd_t                   cmd,
    output srte_pkg::sts_t                   sts,
    output logic                             out_valid,
    input  logic                             out_stall,
    output srte_pkg::out_item_t              out_data
);

    localparam int AW = (MAX_RECORD_BYTES > 1) ? $clog2(MAX_RECORD_BYTES) : 1;
    localparam logic [srte_pkg::CNT_W-1:0] MAX_LEN = srte_pkg::CNT_W'(MAX_RECORD_BYTES);

    logic [1:0]                  type_reg;
    logic [5:0]                  len_reg;
    logic [31:0]                 base_reg;
    logic [srte_pkg::CNT_W-1:0]  fill_reg, fill_next;
    logic [31:0]                 rec_addr_reg, rec_addr_next;
    logic [31:0]                 next_addr_reg, next_addr_next;
    logic [15:0]                 rcount_reg, rcount_next;
    logic [7:0]                  csum_reg, csum_next;
    logic                        out_valid_reg, out_valid_next;
    srte_pkg::out_item_t         out_data_reg;
    srte_pkg::out_item_t         beat;

    logic [1:0]                  eff_type;
    logic [srte_pkg::CNT_W-1:0]  eff_len;
    logic [srte_pkg::CNT_W-1:0]  fill_inc;
    logic [2:0]                  rec_abytes;
    logic [srte_pkg::CNT_W-1:0]  rec_dlen;
    logic [31:0]                 field_addr;
    logic [3:0]                  type_digit;
    logic [7:0]                  addr_byte;
    logic [7:0]                  data_byte;
    logic [7:0]                  count_byte;
    logic [7:0]                  beat_byte;
    logic [31:0]                 start_addr;
    logic [srte_pkg::CNT_W-1:0]  ridx;
    logic                        ram_we;
    logic [7:0]                  ram_rdata;

    // effective configuration
    assign eff_type = (type_reg == 2'd0) ? 2'd1 : type_reg;

    always_comb
    begin
        if (len_reg == 6'd0)
        begin
            eff_len = 6'd1;
        end
        else if (len_reg > MAX_LEN)
        begin
            eff_len = MAX_LEN;
        end
        else
        begin
            eff_len = len_reg;
        end
    end

    assign fill_inc = fill_reg + 6'd1;

    // per-record field values
    always_comb
    begin
        unique case (cmd.kind)
            srte_pkg::REC_HDR:
            begin
                rec_abytes = 3'd2;
                rec_dlen   = 6'd3;
                field_addr = 32'd0;
                type_digit = srte_pkg::TYPE_HEADER;
            end
            srte_pkg::REC_DATA:
            begin
                rec_abytes = (eff_type == 2'd3) ? 3'd4 :
                             (eff_type == 2'd2) ? 3'd3 : 3'd2;
                rec_dlen   = fill_reg;
                field_addr = rec_addr_reg;
                type_digit = {2'b00, eff_type};
            end
            default:
            begin
                rec_abytes = 3'd2;
                rec_dlen   = 6'd0;
                field_addr = {16'd0, rcount_reg};
                type_digit = srte_pkg::TYPE_COUNT;
            end
        endcase
    end

    assign sts.addr_bytes = rec_abytes;
    assign sts.data_len   = rec_dlen;
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign sts.data_flush = (fill_inc >= eff_len) || in_data.block_end;
    assign sts.pending    = (fill_reg != 6'd0);

    assign addr_byte  = 8'(field_addr >> {cmd.idx[1:0], 3'b000});
    assign data_byte  = (cmd.kind == srte_pkg::REC_HDR) ? srte_pkg::hdr_byte(cmd.idx[1:0])
                                                        : ram_rdata;
    assign count_byte = {2'b00, rec_dlen} + {5'd0, rec_abytes} + 8'd1;

    always_comb
    begin
        unique case (cmd.state)
            srte_pkg::ST_COUNT: beat_byte = count_byte;
            srte_pkg::ST_ADDR:  beat_byte = addr_byte;
            srte_pkg::ST_DATA:  beat_byte = data_byte;
            default:            beat_byte = ~csum_reg;
        endcase
    end

    // beat formatting
    always_comb
    begin
        beat.last = cmd.last;
        unique case (cmd.state)
            srte_pkg::ST_HEAD:
            begin
                beat.char_first  = srte_pkg::CHAR_S;
                beat.char_second = srte_pkg::hex_char(type_digit);
                beat.char_count  = 2'd2;
                beat.record_end  = 1'b0;
            end
            srte_pkg::ST_NL:
            begin
                beat.char_first  = srte_pkg::CHAR_NL;
                beat.char_second = 7'd0;
                beat.char_count  = 2'd1;
                beat.record_end  = 1'b1;
            end
            default:
            begin
                beat.char_first  = srte_pkg::hex_char(beat_byte[7:4]);
                beat.char_second = srte_pkg::hex_char(beat_byte[3:0]);
                beat.char_count  = 2'd2;
                beat.record_end  = 1'b0;
            end
        endcase
    end

    // checksum
    always_comb
    begin
        csum_next = csum_reg;
        if (cmd.emit)
        begin
            unique case (cmd.state)
                srte_pkg::ST_HEAD:  csum_next = 8'd0;
                srte_pkg::ST_COUNT,
                srte_pkg::ST_ADDR,
                srte_pkg::ST_DATA:  csum_next = csum_reg + beat_byte;
                default:            csum_next = csum_reg;
            endcase
        end
    end

    // item and record bookkeeping
    assign start_addr = (fill_reg == 6'd0 && in_data.use_address) ? in_data.new_address
                                                                   : next_addr_reg;

    always_comb
    begin
        fill_next      = fill_reg;
        rec_addr_next  = rec_addr_reg;
        next_addr_next = next_addr_reg;
        rcount_next    = rcount_reg;
        if (cmd.accept && in_data.mode == srte_pkg::MODE_START)
        begin
            fill_next      = 6'd0;
            rcount_next    = 16'd0;
            rec_addr_next  = base_reg;
            next_addr_next = base_reg;
        end
        else if (cmd.accept && in_data.mode == srte_pkg::MODE_DATA)
        begin
            if (fill_reg == 6'd0)
            begin
                rec_addr_next = start_addr;
            end
            next_addr_next = start_addr + 32'd1;
            fill_next      = fill_inc;
        end
        else if (cmd.rec_done && cmd.kind == srte_pkg::REC_DATA)
        begin
            fill_next   = 6'd0;
            rcount_next = rcount_reg + 16'd1;
        end
    end

    assign ram_we = cmd.accept && (in_data.mode == srte_pkg::MODE_DATA) && (fill_reg < MAX_LEN);

    // read one index ahead so a data beat can go out every cycle while the output is not stalled
    always_comb
    begin
        if (cmd.state == srte_pkg::ST_DATA)
        begin
            ridx = cmd.emit ? cmd.idx + 6'd1 : cmd.idx;
        end
        else
        begin
            ridx = 6'd0;
        end
    end

    srte_ram #(
        .WIDTH (8),
        .DEPTH (MAX_RECORD_BYTES)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (in_data.data_byte),
        .raddr (ridx[AW-1:0]),
        .rdata (ram_rdata)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_reg      <= srte_pkg::RST_RECORD_TYPE;
            len_reg       <= srte_pkg::RST_RECORD_LENGTH;
            base_reg      <= srte_pkg::RST_BASE_ADDRESS;
            fill_reg      <= 6'd0;
            rec_addr_reg  <= 32'd0;
            next_addr_reg <= 32'd0;
            rcount_reg    <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    srte_pkg::REG_RECORD_TYPE:   type_reg <= cfg_data[1:0];
                    srte_pkg::REG_RECORD_LENGTH: len_reg  <= cfg_data[5:0];
                    srte_pkg::REG_BASE_ADDRESS:  base_reg <= cfg_data;
                    default:                     ;
                endcase
            end
            fill_reg      <= fill_next;
            rec_addr_reg  <= rec_addr_next;
            next_addr_reg <= next_addr_next;
            rcount_reg    <= rcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        csum_reg <= csum_next;
        if (cmd.emit)
        begin
            out_data_reg <= beat;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

>>> rtl/core/srte_ctrl.sv
// ----------------------------------------------------------------------------
// srte_ctrl
// record sequencer: walks header, count, address, data, checksum and
// newline fields one beat at a time
// ----------------------------------------------------------------------------
module srte_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic [1:0]     mode,
    input  srte_pkg::sts_t sts,
    output srte_pkg::cmd_t cmd,
    output logic           busy
);

    srte_pkg::state_t           state_reg, state_next;
    srte_pkg::kind_t            kind_reg, kind_next;
    logic                       trail_reg, trail_next;
    logic [srte_pkg::CNT_W-1:0] idx_reg, idx_next;
    logic                       accept;
    logic                       emit;

    assign accept = in_valid && (state_reg == srte_pkg::ST_IDLE);
    assign emit   = (state_reg != srte_pkg::ST_IDLE) && sts.out_free;

    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        trail_next = trail_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            srte_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (mode)
                        srte_pkg::MODE_START:
                        begin
                            kind_next  = srte_pkg::REC_HDR;
                            trail_next = 1'b0;
                            state_next = srte_pkg::ST_HEAD;
                        end
                        srte_pkg::MODE_DATA:
                        begin
                            if (sts.data_flush)
                            begin
                                kind_next  = srte_pkg::REC_DATA;
                                trail_next = 1'b0;
                                state_next = srte_pkg::ST_HEAD;
                            end
                        end
                        srte_pkg::MODE_FINISH:
                        begin
                            kind_next  = sts.pending ? srte_pkg::REC_DATA : srte_pkg::REC_CNT;
                            trail_next = sts.pending;
                            state_next = srte_pkg::ST_HEAD;
                        end
                        default:
                        begin
                            state_next = srte_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            srte_pkg::ST_HEAD:
            begin
                if (emit)
                begin
                    state_next = srte_pkg::ST_COUNT;
                end
            end
            srte_pkg::ST_COUNT:
            begin
                if (emit)
                begin
                    state_next = srte_pkg::ST_ADDR;
                    idx_next   = {3'b000, sts.addr_bytes} - 6'd1;
                end
            end
            srte_pkg::ST_ADDR:
            begin
                if (emit)
                begin
                    if (idx_reg == 6'd0)
                    begin
                        idx_next   = 6'd0;
                        state_next = (sts.data_len != 6'd0) ? srte_pkg::ST_DATA
                                                            : srte_pkg::ST_CSUM;
                    end
                    else
                    begin
                        idx_next = idx_reg - 6'd1;
                    end
                end
            end
            srte_pkg::ST_DATA:
            begin
                if (emit)
                begin
                    if (idx_reg == sts.data_len - 6'd1)
                    begin
                        state_next = srte_pkg::ST_CSUM;
                    end
                    else
                    begin
                        idx_next = idx_reg + 6'd1;
                    end
                end
            end
            srte_pkg::ST_CSUM:
            begin
                if (emit)
                begin
                    state_next = srte_pkg::ST_NL;
                end
            end
            srte_pkg::ST_NL:
            begin
                if (emit)
                begin
                    if (kind_reg == srte_pkg::REC_DATA && trail_reg)
                    begin
                        kind_next  = srte_pkg::REC_CNT;
                        trail_next = 1'b0;
                        state_next = srte_pkg::ST_HEAD;
                    end
                    else
                    begin
                        state_next = srte_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = srte_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srte_pkg::ST_IDLE;
            kind_reg  <= srte_pkg::REC_HDR;
            trail_reg <= 1'b0;
            idx_reg   <= 6'd0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            trail_reg <= trail_next;
            idx_reg   <= idx_next;
        end
    end

    assign cmd.accept   = accept;
    assign cmd.emit     = emit;
    assign cmd.state    = state_reg;
    assign cmd.kind     = kind_reg;
    assign cmd.idx      = idx_reg;
    assign cmd.last     = (state_reg == srte_pkg::ST_NL)
                          && !(kind_reg == srte_pkg::REC_DATA && trail_reg);
    assign cmd.rec_done = emit && (state_reg == srte_pkg::ST_NL);

    assign busy = (state_reg != srte_pkg::ST_IDLE);

endmodule

>>> rtl/core/srecord_text_encoder.sv
// a data byte that completes no record is taken without stalling the input and yields no beat
// a record with a address bytes and n data bytes is 4 + a + n beats, one per cycle
// while out_stall is low; the taken item is registered as state, then the first beat in the output register
// input stalls from the item that starts a record until its last beat is formed
// rst_n clears all control state and loads register defaults (type 3, length 32)
// the byte buffer holds no reset value; only written entries reach a beat, though others may be read
// ----------------------------------------------------------------------------
// srecord_text_encoder
// turns start, data and finish commands into s-record text beats
// ----------------------------------------------------------------------------
module srecord_text_encoder #(
    parameter int MAX_RECORD_BYTES = srte_pkg::DEF_MAX_RECORD_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [srte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [srte_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  srte_pkg::in_item_t               in_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output srte_pkg::out_item_t              out_data
);

    srte_pkg::cmd_t cmd;
    srte_pkg::sts_t sts;

    srte_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .mode     (in_data.mode),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (in_stall)
    );

    srte_datapath #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

>>> rtl/core/srte_checker.sv
// ----------------------------------------------------------------------------
// srte_checker
// port-level checks on beat flow of the s-record text encoder
// ----------------------------------------------------------------------------
module srte_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input srte_pkg::out_item_t out_data
);

    // stalled beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled output beat changed");

    // no new item while a record is still going out
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |-> in_stall)
        else $error("input open before last beat");

    // beats of one item follow without gaps
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_data.last |=> out_valid)
        else $error("gap inside a record");

    // newline beat carries one character
    a_nl_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.record_end |-> out_data.char_count == 2'd1)
        else $error("record end on a pair beat");

endmodule

bind srecord_text_encoder srte_checker u_srte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

>>> tb/tb_srec_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_srec_pkg
// predicts the text beats of the s-record encoder from accepted commands and
// holds them in order for the output checker
// ----------------------------------------------------------------------------
package tb_srec_pkg;

    import srte_pkg::*;

    localparam logic [1:0] TYPE_NONE   = 2'd0;
    localparam logic [1:0] TYPE_S1     = 2'd1;
    localparam logic [1:0] TYPE_S2     = 2'd2;
    localparam logic [1:0] TYPE_S3     = 2'd3;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int MAX_BYTES   = DEF_MAX_RECORD_BYTES;

    class srec_text_tracker;

        logic [1:0]  rec_type;
        logic [5:0]  rec_len;
        logic [31:0] start_address;

        logic [7:0]  held_bytes[MAX_BYTES];
        int unsigned fill;
        logic [31:0] rec_addr;
        logic [31:0] next_addr;
        logic [15:0] data_records;

        out_item_t   expected_beats[$];
        out_item_t   fresh[$];
        int          errors;

        function new();
            rec_type      = RST_RECORD_TYPE;
            rec_len       = RST_RECORD_LENGTH;
            start_address = RST_BASE_ADDRESS;
            fill          = 0;
            rec_addr      = '0;
            next_addr     = '0;
            data_records  = '0;
            errors        = 0;
        endfunction

        task report(string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void write_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                REG_RECORD_TYPE:   rec_type      = val[1:0];
                REG_RECORD_LENGTH: rec_len       = val[5:0];
                REG_BASE_ADDRESS:  start_address = val;
                default: ;
            endcase
        endfunction

        function int eff_len();
            if (rec_len == 6'd0)
            begin
                return 1;
            end
            if (rec_len > MAX_BYTES)
            begin
                return MAX_BYTES;
            end
            return int'(rec_len);
        endfunction

        function logic [6:0] nib_char(logic [3:0] nib);
            if (nib < 4'd10)
            begin
                return 7'h30 + {3'b000, nib};
            end
            return 7'h41 + {3'b000, nib - 4'd10};
        endfunction

        function void add_beat(logic [6:0] c1, logic [6:0] c2, logic [1:0] cnt,
                               logic rec_end);
            out_item_t b;
            b.char_first  = c1;
            b.char_second = c2;
            b.char_count  = cnt;
            b.record_end  = rec_end;
            b.last        = 1'b0;
            fresh.push_back(b);
        endfunction

        // hex pairs, most significant byte first; returns the byte sum
        function logic [7:0] add_hex(logic [31:0] val, int nbytes);
            logic [7:0] sum;
            logic [7:0] b;
            sum = '0;
            for (int i = nbytes - 1; i >= 0; i--)
            begin
                b = val[8*i +: 8];
                add_beat(nib_char(b[7:4]), nib_char(b[3:0]), 2'd2, 1'b0);
                sum += b;
            end
            return sum;
        endfunction

        function void emit_record_text(logic [3:0] rec_kind, logic [31:0] addr,
                                       logic [7:0] payload[$]);
            int         abytes;
            logic [7:0] sum;
            if (rec_kind == {2'b00, TYPE_S2})
            begin
                abytes = 3;
            end
            else if (rec_kind == {2'b00, TYPE_S3})
            begin
                abytes = 4;
            end
            else
            begin
                abytes = 2;
            end
            add_beat(CHAR_S, 7'h30 + {3'b000, rec_kind}, 2'd2, 1'b0);
            sum = add_hex(abytes + payload.size() + 1, 1);
            sum += add_hex(addr, abytes);
            foreach (payload[i])
            begin
                sum += add_hex({24'd0, payload[i]}, 1);
            end
            void'(add_hex({24'd0, ~sum}, 1));
            add_beat(CHAR_NL, 7'h00, 2'd1, 1'b1);
            if (rec_kind != TYPE_HEADER && rec_kind != TYPE_COUNT)
            begin
                data_records++;
            end
        endfunction

        function void flush_pending_bytes();
            logic [7:0] payload[$];
            logic [1:0] kind;
            if (fill == 0)
            begin
                return;
            end
            for (int i = 0; i < fill; i++)
            begin
                payload.push_back(held_bytes[i]);
            end
            // type zero behaves as 16-bit
            kind = (rec_type == TYPE_NONE) ? TYPE_S1 : rec_type;
            emit_record_text({2'b00, kind}, rec_addr, payload);
            fill = 0;
        endfunction

        function void take_item(in_item_t it);
            out_item_t  tail;
            logic [7:0] hdr[$];
            logic [7:0] none[$];
            fresh.delete();
            case (it.mode)
                MODE_START:
                begin
                    fill         = 0;
                    data_records = '0;
                    next_addr    = start_address;
                    rec_addr     = start_address;
                    hdr          = {8'h48, 8'h44, 8'h52};
                    emit_record_text(TYPE_HEADER, 32'd0, hdr);
                end
                MODE_DATA:
                begin
                    if (fill == 0)
                    begin
                        if (it.use_address)
                        begin
                            next_addr = it.new_address;
                        end
                        rec_addr = next_addr;
                    end
                    held_bytes[fill] = it.data_byte;
                    fill++;
                    next_addr++;
                    if (fill >= eff_len() || it.block_end)
                    begin
                        flush_pending_bytes();
                    end
                end
                MODE_FINISH:
                begin
                    flush_pending_bytes();
                    emit_record_text(TYPE_COUNT, {16'd0, data_records}, none);
                end
                default: ;
            endcase
            if (fresh.size() > 0)
            begin
                tail      = fresh.pop_back();
                tail.last = 1'b1;
                fresh.push_back(tail);
            end
            foreach (fresh[i])
            begin
                expected_beats.push_back(fresh[i]);
            end
        endfunction

        task check_beat(out_item_t got);
            out_item_t want;
            if (expected_beats.size() == 0)
            begin
                report($sformatf("unexpected beat %h", got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.char_first !== want.char_first)
            begin
                report($sformatf("char_first %h, want %h", got.char_first, want.char_first));
            end
            if (got.char_second !== want.char_second)
            begin
                report($sformatf("char_second %h, want %h",
                                 got.char_second, want.char_second));
            end
            if (got.char_count !== want.char_count)
            begin
                report($sformatf("char_count %0d, want %0d", got.char_count, want.char_count));
            end
            if (got.record_end !== want.record_end)
            begin
                report($sformatf("record_end %b, want %b", got.record_end, want.record_end));
            end
            if (got.last !== want.last)
            begin
                report($sformatf("last %b, want %b", got.last, want.last));
            end
        endtask

    endclass

endpackage

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// drives start, data and finish commands into the s-record text encoder with
// random gaps and output stalls, predicts every text beat and checks each one
// ----------------------------------------------------------------------------
module tb_top;

    import srte_pkg::*;
    import tb_srec_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic      in_valid;
    logic      in_stall;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_stall;
    out_item_t out_data;

    srec_text_tracker tracker = new();
    bit steady;
    int stall_left;
    int random_items;

    srecord_text_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(4, 24);
    endfunction

    function automatic in_item_t rand_item(logic [1:0] mode);
        in_item_t it;
        it.mode        = mode;
        it.data_byte   = 8'($urandom);
        it.block_end   = 1'($urandom);
        it.use_address = 1'($urandom);
        it.new_address = $urandom;
        return it;
    endfunction

    function automatic in_item_t data_item(logic [7:0] b, logic bend, logic use_addr,
                                           logic [31:0] addr);
        in_item_t it;
        it.mode        = MODE_DATA;
        it.data_byte   = b;
        it.block_end   = bend;
        it.use_address = use_addr;
        it.new_address = addr;
        return it;
    endfunction

    task automatic send_item(input in_item_t it);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        tracker.take_item(it);
    endtask

    // hold the sender until every predicted beat is out, then let the block settle
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (12) @(posedge clk);
    endtask

    task automatic configure(input logic [1:0] rtype, input logic [5:0] rlen,
                             input logic [31:0] base);
        logic [1:0]  idx[3];
        logic [31:0] vals[3];
        idx  = '{REG_RECORD_TYPE, REG_RECORD_LENGTH, REG_BASE_ADDRESS};
        vals = '{{30'd0, rtype}, {26'd0, rlen}, base};
        cfg_we <= 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            cfg_index <= idx[i];
            cfg_data  <= vals[i];
            @(posedge clk);
            tracker.write_reg(idx[i], vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // output side: check accepted beats, stall at random
    initial
    begin
        out_stall  = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
            begin
                tracker.check_beat(out_data);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!steady && $urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 99) < 70)
                begin
                    stall_left = $urandom_range(0, 1);
                end
                else if ($urandom_range(0, 99) < 80)
                begin
                    stall_left = $urandom_range(2, 5);
                end
                else
                begin
                    stall_left = $urandom_range(6, 23);
                end
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        #25_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          n;
        int          r;
        logic [1:0]  rtype;
        logic [5:0]  rlen;
        logic [31:0] base;
        in_item_t    it;

        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        steady       = 1'b0;
        random_items = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // 32-bit records starting just below the address wrap
        configure(TYPE_S3, 6'd32, 32'hFFFF_FFFE);
        send_item(rand_item(MODE_START));
        send_item(data_item(8'h00, 1'b0, 1'b0, 32'h0));
        send_item(data_item(8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF));
        send_item(data_item(8'hA5, 1'b0, 1'b1, 32'hFFFF_FFFF));
        // new address while bytes are pending is ignored
        send_item(data_item(8'h5A, 1'b1, 1'b1, 32'h1234_5678));
        send_item(data_item(8'hFF, 1'b0, 1'b0, 32'h0));
        send_item(rand_item(MODE_FINISH));
        send_item(rand_item(MODE_UNUSED));
        settle();

        // type zero and length zero
        configure(TYPE_NONE, 6'd0, 32'h0001_FFFF);
        send_item(rand_item(MODE_START));
        send_item(data_item(8'h80, 1'b0, 1'b0, 32'hFFFF_FFFF));
        send_item(data_item(8'h01, 1'b0, 1'b1, 32'h0000_0000));
        send_item(rand_item(MODE_FINISH));
        settle();

        // 24-bit records, oversize length, start drops pending bytes
        configure(TYPE_S2, 6'd63, 32'h00AB_CDEF);
        send_item(rand_item(MODE_START));
        send_item(data_item(8'h11, 1'b0, 1'b1, 32'h5555_AAAA));
        send_item(data_item(8'h22, 1'b0, 1'b0, 32'h0));
        send_item(data_item(8'h33, 1'b0, 1'b0, 32'h0));
        send_item(rand_item(MODE_START));
        send_item(data_item(8'h44, 1'b0, 1'b0, 32'h0));
        send_item(data_item(8'h55, 1'b1, 1'b0, 32'h0));
        send_item(data_item(8'h66, 1'b0, 1'b0, 32'h0));
        send_item(rand_item(MODE_FINISH));

        while (random_items < 300)
        begin
            settle();
            steady = ($urandom_range(0, 3) == 0);
            rtype  = 2'($urandom_range(0, 3));
            r      = $urandom_range(0, 9);
            if (r == 0)
            begin
                rlen = 6'd0;
            end
            else if (r == 1)
            begin
                rlen = 6'd32;
            end
            else if (r == 2)
            begin
                rlen = 6'($urandom_range(33, 63));
            end
            else
            begin
                rlen = 6'($urandom_range(1, 8));
            end
            base = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFF0 + $urandom_range(0, 15)
                                               : $urandom;
            configure(rtype, rlen, base);

            if ($urandom_range(0, 4) != 0)
            begin
                send_item(rand_item(MODE_START));
                random_items++;
            end
            n = $urandom_range(8, 40);
            for (int k = 0; k < n; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    send_item(rand_item(MODE_UNUSED));
                end
                else
                begin
                    if (r < 6)
                    begin
                        it = rand_item(MODE_START);
                    end
                    else if (r < 8)
                    begin
                        it = rand_item(MODE_FINISH);
                    end
                    else
                    begin
                        it = data_item(8'($urandom), $urandom_range(0, 7) == 0,
                                       $urandom_range(0, 3) == 0, $urandom);
                    end
                    send_item(it);
                    random_items++;
                end
                if ($urandom_range(0, 39) == 0)
                begin
                    settle();
                end
            end
            if ($urandom_range(0, 5) != 0)
            begin
                send_item(rand_item(MODE_FINISH));
                random_items++;
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.expected_beats.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (30) @(posedge clk);
        if (tracker.expected_beats.size() != 0)
        begin
            tracker.report($sformatf("%0d beats never came", tracker.expected_beats.size()));
        end
        if (tracker.errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/core/srte_pkg.sv
rtl/core/srte_ram.sv
rtl/core/srte_datapath.sv
rtl/core/srte_ctrl.sv
rtl/core/srecord_text_encoder.sv
rtl/core/srte_checker.sv
tb/tb_srec_pkg.sv
tb/tb_top.sv
